// ----- design/q32d_pkg.sv -----
// shared types and constants for the q32.32 saturating divider
package q32d_pkg;

  localparam int W         = 64;
  localparam int DIV_STEPS = 64;

  typedef logic [W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  localparam word_t SAT_MIN = 64'h8000_0000_0000_0000;
  localparam word_t SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic    neg;
    logic    sat_neg;
    status_t st;
  } side_t;

  typedef struct packed {
    word_t   quotient;
    status_t status;
  } result_t;

endpackage

// ----- design/q32d_if.sv -----
// valid/ready channel interfaces for operand and result items
interface q32d_in_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] dividend;
  logic signed [63:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface q32d_out_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] quotient;
  logic [1:0]         status;

  modport source (output valid, output quotient, output status, input ready);
  modport sink   (input valid, input quotient, input status, output ready);
endinterface

// ----- design/q32d_step.sv -----
// one registered restoring division step, one quotient bit per stage
module q32d_step
  import q32d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  word_t in_rem,
  input  word_t in_lq,
  input  word_t in_mb,
  input  side_t in_side,
  output logic  out_vld_r,
  output word_t out_rem_r,
  output word_t out_lq_r,
  output word_t out_mb_r,
  output side_t out_side_r
);

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         ge;
  word_t        rem_nxt;
  word_t        lq_nxt;

  always_comb begin
    shifted = {in_rem, in_lq[W-1]};
    diff    = {1'b0, shifted} - {2'b00, in_mb};
    ge      = !diff[W+1];
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    lq_nxt  = {in_lq[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_r  <= rem_nxt;
      out_lq_r   <= lq_nxt;
      out_mb_r   <= in_mb;
      out_side_r <= in_side;
    end
  end

endmodule

// ----- design/q32_32_saturating_divide.sv -----
// top level: pipelined signed q32.32 saturating divider
//
// in_ch carries dividend and divisor as raw two's complement q32.32 values;
// out_ch returns quotient and status (ok, overflow saturated, divide by
// zero saturated), one result item per operand item, in order.
// an item is taken when valid and ready are both high at a clock edge.
// the datapath is 68 register stages: operand magnitudes, numerator and
// range check, 64 restoring steps of one quotient bit each, sign and
// saturation, then the output register. throughput is one item per cycle
// while in_ch.ready is high; each stage holds one 65-bit compare and
// subtract at most.
// when out_ch stalls, a second output slot absorbs the item leaving the
// pipeline; in_ch.ready drops only while that slot is full, and the whole
// pipeline then holds, so nothing is lost or repeated.
// rst_n (synchronous, active low) clears all valid bits; items in flight
// are dropped and the block is ready in the next cycle.
module q32_32_saturating_divide
  import q32d_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  q32d_in_if.sink    in_ch,
  q32d_out_if.source out_ch
);

  logic en;
  logic push;
  logic pop;

  // operand stage
  logic  p1_vld_r;
  word_t p1_ma_r;
  word_t p1_mb_r;
  logic  p1_a_neg_r;
  logic  p1_neg_r;
  logic  p1_div0_r;
  word_t ma_nxt;
  word_t mb_nxt;

  // numerator stage and division steps
  logic  vld_r  [0:DIV_STEPS];
  word_t rem_r  [0:DIV_STEPS];
  word_t lq_r   [0:DIV_STEPS];
  word_t mb_r   [0:DIV_STEPS];
  side_t side_r [0:DIV_STEPS];
  logic [2*W-1:0] numer;
  logic  ovf0;
  side_t side_nxt;

  // result stage
  logic    post_vld_r;
  result_t post_r;
  result_t post_nxt;
  word_t   mag;
  word_t   limit;

  // output slots
  logic    out_vld_r;
  result_t out_r;
  logic    skid_vld_r;
  result_t skid_r;

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;
  assign push        = en && post_vld_r;
  assign pop         = out_vld_r && out_ch.ready;

  always_comb begin
    ma_nxt = in_ch.dividend[W-1] ? (~in_ch.dividend + 64'd1) : in_ch.dividend;
    mb_nxt = in_ch.divisor[W-1]  ? (~in_ch.divisor + 64'd1)  : in_ch.divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ma_r    <= ma_nxt;
      p1_mb_r    <= mb_nxt;
      p1_a_neg_r <= in_ch.dividend[W-1];
      p1_neg_r   <= in_ch.dividend[W-1] ^ in_ch.divisor[W-1];
      p1_div0_r  <= (in_ch.divisor == '0);
    end
  end

  always_comb begin
    numer = {{W{1'b0}}, p1_ma_r} << FRAC_BITS;
    ovf0  = numer[2*W-1:W] >= p1_mb_r;
    side_nxt.neg = p1_neg_r;
    priority if (p1_div0_r) begin
      side_nxt.st      = ST_DIV0;
      side_nxt.sat_neg = p1_a_neg_r;
    end else if (ovf0) begin
      side_nxt.st      = ST_OVF;
      side_nxt.sat_neg = p1_neg_r;
    end else begin
      side_nxt.st      = ST_OK;
      side_nxt.sat_neg = p1_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf0 ? '0 : numer[2*W-1:W];
      lq_r[0]   <= numer[W-1:0];
      mb_r[0]   <= p1_mb_r;
      side_r[0] <= side_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    q32d_step u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_vld     (vld_r[i]),
      .in_rem     (rem_r[i]),
      .in_lq      (lq_r[i]),
      .in_mb      (mb_r[i]),
      .in_side    (side_r[i]),
      .out_vld_r  (vld_r[i+1]),
      .out_rem_r  (rem_r[i+1]),
      .out_lq_r   (lq_r[i+1]),
      .out_mb_r   (mb_r[i+1]),
      .out_side_r (side_r[i+1])
    );
  end

  always_comb begin
    mag   = lq_r[DIV_STEPS];
    limit = side_r[DIV_STEPS].neg ? SAT_MIN : SAT_MAX;
    post_nxt.status = side_r[DIV_STEPS].st;
    if (side_r[DIV_STEPS].st == ST_OK && mag > limit) begin
      post_nxt.status = ST_OVF;
    end
    if (post_nxt.status == ST_OK) begin
      post_nxt.quotient = side_r[DIV_STEPS].neg ? (~mag + 64'd1) : mag;
    end else begin
      post_nxt.quotient = side_r[DIV_STEPS].sat_neg ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= 1'b0;
    end else if (en) begin
      post_vld_r <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_r <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (out_vld_r && !pop) begin
      skid_vld_r <= push;
    end else begin
      out_vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (out_vld_r && !pop) begin
      if (push) begin
        skid_r <= post_r;
      end
    end else if (push) begin
      out_r <= post_r;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.quotient = out_r.quotient;
  assign out_ch.status   = out_r.status;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid slot full while output register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready && push && !skid_vld_r) |=> skid_vld_r)
    else $error("item leaving pipeline during stall was not held");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !skid_vld_r && !push) |=> !out_vld_r)
    else $error("taken item stayed in output register");

  a_div0_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == ST_DIV0) |->
      (out_r.quotient == SAT_MIN || out_r.quotient == SAT_MAX))
    else $error("divide by zero result not saturated");
`endif

endmodule
